// ===== rtl/psa_pkg.sv =====
package psa_pkg;

   localparam int unsigned POOL_SLOTS_DEFAULT = 1024;

   localparam int unsigned SLOT_W   = 10;
   localparam int unsigned LIVE_W   = 11;
   localparam int unsigned STATUS_W = 2;

   // request codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EXHAUSTED = 2'd1,
      STATUS_IGNORED   = 2'd2,
      STATUS_OVERFLOW  = 2'd3
   } status_type;

   typedef struct packed {
      status_type              status;
      logic [SLOT_W-1:0]       granted_slot;
      logic [LIVE_W-1:0]       live_slots;
   } rsp_type;

endpackage

// ===== rtl/psa_ifs.sv =====
interface psa_req_if;
   import psa_pkg::*;

   logic              valid;
   logic              ready;
   logic              operation;
   logic [SLOT_W-1:0] slot_index;

   modport source (output valid, output operation, output slot_index, input ready);
   modport sink   (input valid, input operation, input slot_index, output ready);
endinterface

interface psa_rsp_if;
   import psa_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   granted_slot;
   logic [LIVE_W-1:0]   live_slots;

   modport source (output valid, output status, output granted_slot, output live_slots,
                   input ready);
   modport sink   (input valid, input status, input granted_slot, input live_slots,
                   output ready);
endinterface

// ===== rtl/psa_ram.sv =====
module psa_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/psa_rsp_fifo.sv =====
module psa_rsp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  psa_pkg::rsp_type push_data,
   input  logic             pop,
   output logic             out_valid,
   output psa_pkg::rsp_type out_data,
   output logic             full
);
   import psa_pkg::*;

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign full      = (count_ff == 2'd2);

endmodule

// ===== rtl/pool_slot_allocator.sv =====
// channel   dir  handshake        payload
// req_bus   in   valid / ready    operation, slot_index
// rsp_bus   out  valid / ready    status, granted_slot, live_slots
//
// one item at a time: an allocate served from the free stack first reads the stack
// memory (state ST_POP), every other item is answered as it is accepted
// synchronous reset clears bump pointer, live count, stack fill and control;
// stack memory is not cleared, only entries below the fill are ever read
// a two-entry result queue holds results while rsp_bus stalls; req_bus
// stalls only when that queue is full or a stack read is in flight
module pool_slot_allocator #(
   parameter int unsigned POOL_SLOTS = psa_pkg::POOL_SLOTS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   psa_req_if.sink   req_bus,
   psa_rsp_if.source rsp_bus
);
   import psa_pkg::*;

   // stack address and counter widths (counters must hold POOL_SLOTS itself)
   localparam int unsigned AW = $clog2(POOL_SLOTS);
   localparam int unsigned CW = $clog2(POOL_SLOTS + 1);
   localparam logic [CW-1:0] POOL_LIMIT = CW'(POOL_SLOTS);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,   // ready for the next item
      ST_POP  = 2'b10    // stack read in flight, result next cycle
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] bump_ff, bump_in;   // next never-used slot
   logic [CW-1:0] live_ff, live_in;   // slots handed out and not yet freed
   logic [CW-1:0] fill_ff, fill_in;   // free stack depth

   // free stack memory
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [SLOT_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [SLOT_W-1:0] ram_rd_data;

   // result queue
   logic    q_push;
   rsp_type q_push_data;
   logic    q_pop;
   logic    q_valid;
   rsp_type q_data;
   logic    q_full;

   logic          req_fire;
   logic          slot_in_range;
   logic [CW-1:0] live_dec;

   assign req_bus.ready = (state_ff == ST_IDLE) && !q_full;
   assign req_fire      = req_bus.valid && req_bus.ready;

   // slots at or beyond the pool size are treated like a free while idle
   assign slot_in_range = (32'(req_bus.slot_index) < POOL_SLOTS);
   assign live_dec      = live_ff - CW'(1);

   always_comb begin
      state_in = state_ff;
      bump_in  = bump_ff;
      live_in  = live_ff;
      fill_in  = fill_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = AW'(fill_ff);
      ram_wr_data = req_bus.slot_index;
      ram_rd_en   = 1'b0;
      ram_rd_addr = AW'(fill_ff - CW'(1));

      q_push                   = 1'b0;
      q_push_data.status       = STATUS_OK;
      q_push_data.granted_slot = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.operation == OP_ALLOC) begin
                  if (bump_ff < POOL_LIMIT) begin
                     // fresh slot from the bump pointer
                     q_push                   = 1'b1;
                     q_push_data.granted_slot = SLOT_W'(bump_ff);
                     bump_in                  = bump_ff + CW'(1);
                     live_in                  = live_ff + CW'(1);
                  end else if (fill_ff == '0) begin
                     q_push             = 1'b1;
                     q_push_data.status = STATUS_EXHAUSTED;
                  end else begin
                     // pop: read the top of stack, answer next cycle
                     ram_rd_en = 1'b1;
                     fill_in   = fill_ff - CW'(1);
                     live_in   = live_ff + CW'(1);
                     state_in  = ST_POP;
                  end
               end else begin
                  q_push = 1'b1;
                  if (live_ff == '0 || !slot_in_range) begin
                     q_push_data.status = STATUS_IGNORED;
                  end else if (fill_ff == POOL_LIMIT) begin
                     // only a free of a slot that is not live can get here
                     q_push_data.status = STATUS_OVERFLOW;
                  end else begin
                     ram_wr_en = 1'b1;
                     live_in   = live_dec;
                     fill_in   = fill_ff + CW'(1);
                     if (live_dec == '0) begin
                        // pool drained, start over
                        bump_in = '0;
                        fill_in = '0;
                     end
                  end
               end
            end
         end
         ST_POP: begin
            q_push                   = 1'b1;
            q_push_data.granted_slot = ram_rd_data;
            state_in                 = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      q_push_data.live_slots = LIVE_W'(live_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bump_ff  <= '0;
         live_ff  <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         bump_ff  <= bump_in;
         live_ff  <= live_in;
         fill_ff  <= fill_in;
      end
   end

   psa_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (POOL_SLOTS)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   psa_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .out_valid (q_valid),
      .out_data  (q_data),
      .full      (q_full)
   );

   assign q_pop                = rsp_bus.valid && rsp_bus.ready;
   assign rsp_bus.valid        = q_valid;
   assign rsp_bus.status       = q_data.status;
   assign rsp_bus.granted_slot = q_data.granted_slot;
   assign rsp_bus.live_slots   = q_data.live_slots;

endmodule

// ===== tb/psa_allocation_checker.sv =====
`timescale 1ns / 1ps

module psa_allocation_checker (
   input  logic        clock,
   input  logic        reset,
   psa_req_if          req_mon,
   psa_rsp_if          rsp_mon,
   output int unsigned results_pending,
   output int unsigned mismatch_count
);
   import psa_pkg::*;

   localparam int unsigned POOL = POOL_SLOTS_DEFAULT;

   // shadow of the allocator state
   logic [LIVE_W-1:0] next_fresh;
   logic [LIVE_W-1:0] live_total;
   logic [LIVE_W-1:0] stack_depth;
   logic [SLOT_W-1:0] recycled [POOL];

   rsp_type expected_grants [$];

   function automatic rsp_type predict_grant(input logic op, input logic [SLOT_W-1:0] slot);
      rsp_type r;
      r.status       = STATUS_OK;
      r.granted_slot = '0;
      if (op == OP_ALLOC) begin
         if (next_fresh < POOL) begin
            r.granted_slot = next_fresh[SLOT_W-1:0];
            next_fresh     = next_fresh + 1'b1;
            live_total     = live_total + 1'b1;
         end else if (stack_depth == '0) begin
            r.status = STATUS_EXHAUSTED;
         end else begin
            stack_depth    = stack_depth - 1'b1;
            r.granted_slot = recycled[stack_depth];
            live_total     = live_total + 1'b1;
         end
      end else if (live_total == '0 || slot >= POOL) begin
         r.status = STATUS_IGNORED;
      end else if (stack_depth >= POOL) begin
         r.status = STATUS_OVERFLOW;
      end else begin
         live_total           = live_total - 1'b1;
         recycled[stack_depth] = slot;
         stack_depth          = stack_depth + 1'b1;
         // last live slot returned: pool starts over
         if (live_total == '0) begin
            next_fresh  = '0;
            stack_depth = '0;
         end
      end
      r.live_slots = live_total;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         next_fresh  = '0;
         live_total  = '0;
         stack_depth = '0;
         expected_grants.delete();
         mismatch_count = 0;
      end else begin
         // request first, so a same-edge result still finds its expectation
         if (req_mon.valid && req_mon.ready)
            expected_grants.push_back(predict_grant(req_mon.operation, req_mon.slot_index));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_grants.size() == 0) begin
               $error("unexpected result item: status %0d granted_slot %0d live_slots %0d",
                      rsp_mon.status, rsp_mon.granted_slot, rsp_mon.live_slots);
               mismatch_count++;
            end else begin
               want = expected_grants.pop_front();
               if (rsp_mon.status !== want.status) begin
                  $error("status: expected %0d actual %0d", want.status, rsp_mon.status);
                  mismatch_count++;
               end
               if (rsp_mon.granted_slot !== want.granted_slot) begin
                  $error("granted_slot: expected %0d actual %0d",
                         want.granted_slot, rsp_mon.granted_slot);
                  mismatch_count++;
               end
               if (rsp_mon.live_slots !== want.live_slots) begin
                  $error("live_slots: expected %0d actual %0d",
                         want.live_slots, rsp_mon.live_slots);
                  mismatch_count++;
               end
            end
         end
      end
      results_pending = expected_grants.size();
   end

endmodule

// ===== tb/tb_pool_slot_allocator.sv =====
`timescale 1ns / 1ps

module tb_pool_slot_allocator;
   import psa_pkg::*;

   localparam int unsigned POOL        = POOL_SLOTS_DEFAULT;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned HOLD_CYCLES = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   psa_req_if req_bus ();
   psa_rsp_if rsp_bus ();

   int unsigned results_pending;
   int unsigned mismatch_count;
   int unsigned cycle_count = 0;

   // idle rates in percent, receiver side read by its own process
   int unsigned send_idle_pct = 0;
   int unsigned rsp_idle_pct  = 0;

   // one long receiver hold-off, requested by the stimulus
   logic        hold_go   = 1'b0;
   logic        hold_done = 1'b0;
   int unsigned hold_left = 0;

   // stimulus bookkeeping: slots believed live, ops still waiting for a result
   logic [SLOT_W-1:0] live_pool [$];
   logic              ops_in_flight [$];
   int unsigned       live_cap = 1;

   pool_slot_allocator dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   psa_allocation_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .results_pending (results_pending),
      .mismatch_count  (mismatch_count)
   );

   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off so the result queue fills
   // and the block has to stall its request side
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left     <= hold_left - 1;
         end else if (hold_go && !hold_done) begin
            rsp_bus.ready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_done     <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // learn which slots were granted, so frees can mostly name live slots
   always @(posedge clock) begin
      logic op;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            ops_in_flight.push_back(req_bus.operation);
         if (rsp_bus.valid && rsp_bus.ready && ops_in_flight.size() != 0) begin
            op = ops_in_flight.pop_front();
            // pool went empty: everything we remember is stale
            if (rsp_bus.live_slots == '0)
               live_pool.delete();
            else if (op == OP_ALLOC && rsp_bus.status == STATUS_OK)
               live_pool.push_back(rsp_bus.granted_slot);
         end
      end
   end

   // offer one item, with random idle cycles ahead of it, and wait for acceptance
   task automatic offer(input logic op, input logic [SLOT_W-1:0] slot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= op;
      req_bus.slot_index <= slot;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
   endtask

   // mostly well-formed alloc/free traffic; the live count wanders up to a
   // random cap, picked anew whenever the pool empties and restarts
   task automatic alloc_free_mix(input int unsigned n_items, input int unsigned cap_max,
                                 input int unsigned free_pct);
      int unsigned pick;
      logic [SLOT_W-1:0] slot;
      for (int unsigned i = 0; i < n_items; i++) begin
         if (live_pool.size() == 0)
            live_cap = $urandom_range(cap_max, 1);
         if ($urandom_range(99) < 8) begin
            // noise: double frees, frees of never-granted slots, frees while idle
            offer(1'($urandom_range(1)), SLOT_W'($urandom_range(POOL - 1)));
         end else if (live_pool.size() != 0 &&
                      (live_pool.size() >= live_cap || $urandom_range(99) < free_pct)) begin
            pick = $urandom_range(live_pool.size() - 1);
            slot = live_pool[pick];
            live_pool.delete(pick);
            offer(OP_FREE, slot);
         end else begin
            // slot_index is don't-care on allocate, so keep it random
            offer(OP_ALLOC, SLOT_W'($urandom_range(POOL - 1)));
         end
      end
   endtask

   initial begin
      req_bus.valid      <= 1'b0;
      req_bus.operation  <= OP_ALLOC;
      req_bus.slot_index <= '0;

      // sender mostly busy, receiver mostly stalled
      send_idle_pct = 6;
      rsp_idle_pct  <= 66;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // free while the pool is idle, both index extremes
      offer(OP_FREE, '0);
      offer(OP_FREE, '1);
      // fresh grants from the bump pointer
      offer(OP_ALLOC, '1);
      offer(OP_ALLOC, '0);
      offer(OP_ALLOC, 10'h155);
      // free, then double free of the same slot, both accepted
      offer(OP_FREE, 10'd1);
      offer(OP_FREE, 10'd1);
      // more grants, still from the bump pointer
      offer(OP_ALLOC, 10'h2AA);
      offer(OP_ALLOC, '0);
      offer(OP_ALLOC, '0);
      // free of a slot never handed out
      offer(OP_FREE, '1);
      // drain to zero, which clears the pool
      offer(OP_FREE, 10'd0);
      offer(OP_FREE, 10'd2);
      offer(OP_FREE, 10'd3);
      offer(OP_FREE, 10'd5);
      // after the clear, grants restart at slot zero
      offer(OP_ALLOC, '0);
      offer(OP_ALLOC, '0);
      offer(OP_FREE, 10'd1);
      offer(OP_FREE, 10'd0);

      alloc_free_mix(250, 12, 45);

      // sender mostly idle, receiver mostly ready
      send_idle_pct = 66;
      rsp_idle_pct  <= 6;
      alloc_free_mix(250, 12, 45);

      // no idling at all; long receiver hold-off while the pool fills up
      send_idle_pct = 0;
      rsp_idle_pct  <= 0;
      hold_go       <= 1'b1;
      // enough allocates to use every slot and then hit exhaustion
      for (int unsigned i = 0; i < POOL + 6; i++)
         offer(OP_ALLOC, SLOT_W'($urandom_range(POOL - 1)));
      // deep stack traffic: many frees, pops from a tall stack
      alloc_free_mix(500, POOL, 65);
      alloc_free_mix(200, 8, 50);

      req_bus.valid <= 1'b0;

      while (results_pending != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/psa_pkg.sv
rtl/psa_ifs.sv
rtl/psa_ram.sv
rtl/psa_rsp_fifo.sv
rtl/pool_slot_allocator.sv
tb/psa_allocation_checker.sv
tb/tb_pool_slot_allocator.sv
